/* rtl/core/tpc_pkg.sv */
// Shared types and constants of the touch press classifier.
// Configuration register map, reset values and the records that pass between stages.
// No dependencies.
`default_nettype none

package tpc_pkg;

    localparam int RD_W       = 16;   // one raw sensor reading
    localparam int TIME_W     = 32;   // millisecond timestamp
    localparam int CFG_W      = 16;   // every configuration register
    localparam int CFG_ADDR_W = 3;
    localparam int OUT_TDATA_W = 8;

    // Kinds of poll.
    localparam logic KIND_LONG_CHECK  = 1'b0;
    localparam logic KIND_SHORT_CHECK = 1'b1;

    // Configuration register indices.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TOUCH_THRESHOLD = 3'd0,
        REG_LONG_PRESS_MS   = 3'd1,
        REG_LOCKOUT_MS      = 3'd2,
        REG_TAP_MIN_MS      = 3'd3,
        REG_TAP_MAX_MS      = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_W-1:0] touch_threshold;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] lockout_ms;
        logic [CFG_W-1:0] tap_min_ms;
        logic [CFG_W-1:0] tap_max_ms;
    } tpc_cfg_t;

    localparam tpc_cfg_t CFG_RESET = '{
        touch_threshold: 16'd40,
        long_press_ms:   16'd1000,
        lockout_ms:      16'd1000,
        tap_min_ms:      16'd100,
        tap_max_ms:      16'd2000
    };

    // One poll after the readings have been reduced to a touch decision.
    typedef struct packed {
        logic              kind;
        logic [TIME_W-1:0] now_ms;
        logic              touched;
    } tpc_poll_t;

    // One result item; long_press sits in the lowest bit of tdata.
    typedef struct packed {
        logic touched_now;
        logic short_tap;
        logic long_press;
    } tpc_result_t;

    localparam int RESULT_W = $bits(tpc_result_t);

endpackage

`default_nettype wire

/* rtl/core/tpc_lane.sv */
// One reading lane of the touch press classifier: captures one raw reading of a poll
// and widens it to the width of the merged sum. Depends on tpc_pkg.
`default_nettype none

module tpc_lane #(
    parameter int SUM_W = 19
) (
    input  wire logic                     aclk,
    input  wire logic                     load,
    input  wire logic [tpc_pkg::RD_W-1:0] reading_in,
    output logic      [SUM_W-1:0]         reading_out
);

    logic [SUM_W-1:0] reading_reg;

    always_ff @(posedge aclk) begin
        if (load) begin
            reading_reg <= SUM_W'(reading_in);
        end
    end

    assign reading_out = reading_reg;

endmodule

`default_nettype wire

/* rtl/core/tpc_merge.sv */
// Merging stage of the touch press classifier: sums the lane readings and decides touch.
// Depends on tpc_pkg.
`default_nettype none

module tpc_merge #(
    parameter int NUM_READINGS = 5,
    localparam int SUM_W = tpc_pkg::RD_W + $clog2(NUM_READINGS)
) (
    input  wire logic                        aclk,
    input  wire logic                        load,
    input  wire logic [SUM_W-1:0]            lane_val [NUM_READINGS],
    input  wire logic [tpc_pkg::CFG_W-1:0]   threshold,
    input  wire logic                        kind_in,
    input  wire logic [tpc_pkg::TIME_W-1:0]  now_in,
    output tpc_pkg::tpc_poll_t               poll_out
);

    logic [SUM_W-1:0]   sum;
    logic [SUM_W-1:0]   thr_scaled;
    tpc_pkg::tpc_poll_t poll_reg;

    always_comb begin
        sum = '0;
        for (int i = 0; i < NUM_READINGS; i++) begin
            sum = sum + lane_val[i];
        end
    end

    // The truncated average lies below the threshold exactly when the sum lies
    // below threshold times the reading count, so no divider is needed.
    assign thr_scaled = SUM_W'(threshold) * SUM_W'(NUM_READINGS);

    always_ff @(posedge aclk) begin
        if (load) begin
            poll_reg.kind    <= kind_in;
            poll_reg.now_ms  <= now_in;
            poll_reg.touched <= (sum < thr_scaled);
        end
    end

    assign poll_out = poll_reg;

endmodule

`default_nettype wire

/* rtl/core/tpc_decide.sv */
// Press state of the touch press classifier: press tracking, tap arming, lockout,
// and the registered result. Depends on tpc_pkg.
`default_nettype none

module tpc_decide (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                load,
    input  wire tpc_pkg::tpc_cfg_t   cfg,
    input  wire tpc_pkg::tpc_poll_t  poll,
    output tpc_pkg::tpc_result_t     result
);

    logic                        pressing_reg,      pressing_next;
    logic [tpc_pkg::TIME_W-1:0]  press_start_reg,   press_start_next;
    logic                        tap_armed_reg,     tap_armed_next;
    logic [tpc_pkg::TIME_W-1:0]  last_tap_reg,      last_tap_next;
    tpc_pkg::tpc_result_t        result_reg,        result_next;

    logic [tpc_pkg::TIME_W-1:0]  start_eff;
    logic [tpc_pkg::TIME_W-1:0]  held_ms;
    logic [tpc_pkg::TIME_W-1:0]  press_ms;
    logic [tpc_pkg::TIME_W-1:0]  since_tap_ms;
    logic [tpc_pkg::TIME_W-1:0]  long_ms;
    logic                        lp;
    logic                        st;

    always_comb begin
        // A touch that finds no press in progress starts one now.
        start_eff    = pressing_reg ? press_start_reg : poll.now_ms;
        held_ms      = poll.now_ms - start_eff;
        press_ms     = poll.now_ms - press_start_reg;
        since_tap_ms = poll.now_ms - last_tap_reg;
        long_ms      = tpc_pkg::TIME_W'(cfg.long_press_ms);

        pressing_next    = pressing_reg;
        press_start_next = press_start_reg;
        tap_armed_next   = tap_armed_reg;
        last_tap_next    = last_tap_reg;
        lp               = 1'b0;
        st               = 1'b0;

        if (poll.kind == tpc_pkg::KIND_LONG_CHECK) begin
            if (poll.touched) begin
                if (held_ms >= long_ms) begin
                    pressing_next    = 1'b0;
                    press_start_next = '0;
                    lp               = 1'b1;
                end else begin
                    pressing_next    = 1'b1;
                    press_start_next = start_eff;
                end
            end else if (pressing_reg) begin
                pressing_next    = 1'b0;
                press_start_next = '0;
            end
        end else if (since_tap_ms >= tpc_pkg::TIME_W'(cfg.lockout_ms)) begin
            if (poll.touched) begin
                pressing_next    = 1'b1;
                press_start_next = start_eff;
                tap_armed_next   = (held_ms < long_ms);
            end else if (pressing_reg) begin
                // Release on a short check keeps the start time.
                pressing_next = 1'b0;
                if (tap_armed_reg && (press_ms < long_ms) &&
                    (press_ms >= tpc_pkg::TIME_W'(cfg.tap_min_ms)) &&
                    (press_ms <= tpc_pkg::TIME_W'(cfg.tap_max_ms))) begin
                    tap_armed_next = 1'b0;
                    last_tap_next  = poll.now_ms;
                    st             = 1'b1;
                end
            end
        end

        result_next.long_press  = lp;
        result_next.short_tap   = st;
        result_next.touched_now = pressing_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pressing_reg    <= 1'b0;
            press_start_reg <= '0;
            tap_armed_reg   <= 1'b0;
            last_tap_reg    <= '0;
        end else if (load) begin
            pressing_reg    <= pressing_next;
            press_start_reg <= press_start_next;
            tap_armed_reg   <= tap_armed_next;
            last_tap_reg    <= last_tap_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

/* rtl/core/touch_press_classifier.sv */
// Top level of the touch press classifier: configuration registers, lane array,
// merging stage, press state and the transfer handshakes. Depends on tpc_pkg,
// tpc_lane, tpc_merge and tpc_decide.
`default_nettype none

// The block takes one poll per transfer on the slave side and returns exactly one
// result per poll on the master side, in order. A poll carries a kind in s_tuser
// (long-press check or short-tap check), a millisecond timestamp and the raw touch
// readings in s_tdata. Each reading has a lane of its own; the merging stage adds
// the lane values and compares the sum with the touch threshold scaled by the
// reading count, which gives the same answer as comparing the truncated average.
// The press state is updated combinationally ahead of the result register, so the block
// sustains one poll per clock while m_tready stays high; a poll passes through the lane
// registers, the merge register and the result register before m_tvalid rises. The slave
// side keeps accepting while a result waits, as long as a pipeline stage is free.
// Configuration registers are written through cfg_wr_en, cfg_addr and cfg_wr_data, and
// should only be written while no poll is in flight; indices beyond the last register
// are ignored. Timestamps are compared with 32-bit wraparound.
module touch_press_classifier #(
    parameter int NUM_READINGS = 5
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Configuration write port.
    input  wire logic                                cfg_wr_en,
    input  wire logic [tpc_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [tpc_pkg::CFG_W-1:0]           cfg_wr_data,
    // Poll input.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // tdata, lowest bit first: now_ms[31:0], reading_a, reading_b, ... (16 bits each)
    input  wire logic [tpc_pkg::TIME_W+NUM_READINGS*tpc_pkg::RD_W-1:0] s_tdata,
    // tuser: kind
    input  wire logic                                s_tuser,
    // Result output.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // tdata, lowest bit first: long_press, short_tap, touched_now, zero padding
    output logic [tpc_pkg::OUT_TDATA_W-1:0]          m_tdata
);

    localparam int SUM_W = tpc_pkg::RD_W + $clog2(NUM_READINGS);

    // Configuration registers.
    tpc_pkg::tpc_cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                tpc_pkg::REG_TOUCH_THRESHOLD: cfg_next.touch_threshold = cfg_wr_data;
                tpc_pkg::REG_LONG_PRESS_MS:   cfg_next.long_press_ms   = cfg_wr_data;
                tpc_pkg::REG_LOCKOUT_MS:      cfg_next.lockout_ms      = cfg_wr_data;
                tpc_pkg::REG_TAP_MIN_MS:      cfg_next.tap_min_ms      = cfg_wr_data;
                tpc_pkg::REG_TAP_MAX_MS:      cfg_next.tap_max_ms      = cfg_wr_data;
                default:                      cfg_next                 = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= tpc_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Pipeline occupancy. A stage loads when it is empty or when its contents move on in
    // the same cycle, so with m_tready high a full pipeline still advances one poll per clock.
    logic lane_valid_reg,  lane_valid_next;
    logic merge_valid_reg, merge_valid_next;
    logic out_valid_reg,   out_valid_next;
    logic accept;
    logic load_merge;
    logic load_out;

    assign load_out   = merge_valid_reg && (!out_valid_reg || m_tready);
    assign load_merge = lane_valid_reg && (!merge_valid_reg || load_out);
    assign s_tready   = !lane_valid_reg || load_merge;
    assign accept     = s_tvalid && s_tready;

    always_comb begin
        lane_valid_next  = lane_valid_reg;
        merge_valid_next = merge_valid_reg;
        out_valid_next   = out_valid_reg;
        if (accept) begin
            lane_valid_next = 1'b1;
        end else if (load_merge) begin
            lane_valid_next = 1'b0;
        end
        if (load_merge) begin
            merge_valid_next = 1'b1;
        end else if (load_out) begin
            merge_valid_next = 1'b0;
        end
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lane_valid_reg  <= 1'b0;
            merge_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            lane_valid_reg  <= lane_valid_next;
            merge_valid_reg <= merge_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Kind and timestamp travel alongside the lane registers.
    logic                        kind_reg;
    logic [tpc_pkg::TIME_W-1:0]  now_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= s_tuser;
            now_reg  <= s_tdata[tpc_pkg::TIME_W-1:0];
        end
    end

    // One lane per reading.
    logic [SUM_W-1:0] lane_val [NUM_READINGS];

    for (genvar g = 0; g < NUM_READINGS; g++) begin : g_lane
        tpc_lane #(
            .SUM_W (SUM_W)
        ) u_lane (
            .aclk        (aclk),
            .load        (accept),
            .reading_in  (s_tdata[tpc_pkg::TIME_W + g*tpc_pkg::RD_W +: tpc_pkg::RD_W]),
            .reading_out (lane_val[g])
        );
    end

    tpc_pkg::tpc_poll_t   poll;
    tpc_pkg::tpc_result_t result;

    tpc_merge #(
        .NUM_READINGS (NUM_READINGS)
    ) u_merge (
        .aclk      (aclk),
        .load      (load_merge),
        .lane_val  (lane_val),
        .threshold (cfg_reg.touch_threshold),
        .kind_in   (kind_reg),
        .now_in    (now_reg),
        .poll_out  (poll)
    );

    tpc_decide u_decide (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load_out),
        .cfg     (cfg_reg),
        .poll    (poll),
        .result  (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(tpc_pkg::OUT_TDATA_W - tpc_pkg::RESULT_W){1'b0}}, result};

    // A single poll never reports both a long press and a tap.
    a_one_event : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(result.long_press && result.short_tap))
        else $error("long press and short tap reported together");

    // A long press clears the press, so it is never reported as still touched.
    a_long_clears : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && result.long_press) |-> !result.touched_now)
        else $error("long press reported with press still in progress");

    // With every stage full and the output stalled, no new poll may enter.
    a_full_stall : assert property (@(posedge aclk) disable iff (!aresetn)
        (lane_valid_reg && merge_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("poll accepted while pipeline is full and stalled");

endmodule

`default_nettype wire

/* tb/tpc_press_checker.sv */
`timescale 1ns / 1ps
// Result checker for the touch press classifier: follows the configuration port and both
// stream channels, predicts every result and compares it field by field. Depends on tpc_pkg.
module tpc_press_checker #(
    parameter int NUM_READINGS = 5
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      cfg_wr_en,
    input  logic [tpc_pkg::CFG_ADDR_W-1:0]            cfg_addr,
    input  logic [tpc_pkg::CFG_W-1:0]                 cfg_wr_data,
    input  logic                                      s_tvalid,
    input  logic                                      s_tready,
    input  logic [tpc_pkg::TIME_W+NUM_READINGS*tpc_pkg::RD_W-1:0] s_tdata,
    input  logic                                      s_tuser,
    input  logic                                      m_tvalid,
    input  logic                                      m_tready,
    input  logic [tpc_pkg::OUT_TDATA_W-1:0]           m_tdata,
    output int                                        outstanding,
    output int                                        fail_count
);
    import tpc_pkg::*;

    tpc_cfg_t          cfg_copy;
    logic              pressing;
    logic [TIME_W-1:0] press_start;
    logic              tap_armed;
    logic [TIME_W-1:0] last_tap_time;
    tpc_result_t       expected_results [$];

    // The average is truncated and kept to 16 bits before the threshold compare.
    function automatic logic poll_touched(input logic [TIME_W+NUM_READINGS*RD_W-1:0] data);
        logic [31:0] sum;
        logic [31:0] mean;
        int          i;
        sum = '0;
        for (i = 0; i < NUM_READINGS; i++) begin
            sum += 32'(data[TIME_W + i*RD_W +: RD_W]);
        end
        mean = sum / NUM_READINGS;
        return mean[RD_W-1:0] < cfg_copy.touch_threshold;
    endfunction

    function automatic void start_press(input logic [TIME_W-1:0] now);
        if (!pressing) begin
            pressing    = 1'b1;
            press_start = now;
        end
    endfunction

    function automatic tpc_result_t classify_poll(input logic kind,
                                                  input logic [TIME_W-1:0] now,
                                                  input logic touched);
        tpc_result_t       res;
        logic [TIME_W-1:0] held;
        logic [TIME_W-1:0] since_tap;
        res = '0;
        since_tap = now - last_tap_time;
        if (kind == KIND_LONG_CHECK) begin
            if (touched) begin
                start_press(now);
                held = now - press_start;
                if (held >= 32'(cfg_copy.long_press_ms)) begin
                    pressing       = 1'b0;
                    press_start    = '0;
                    res.long_press = 1'b1;
                end
            end else if (pressing) begin
                pressing    = 1'b0;
                press_start = '0;
            end
        end else if (since_tap >= 32'(cfg_copy.lockout_ms)) begin
            if (touched) begin
                start_press(now);
                held      = now - press_start;
                tap_armed = held < 32'(cfg_copy.long_press_ms);
            end else if (pressing) begin
                // A release keeps press_start; only a long check clears it.
                held     = now - press_start;
                pressing = 1'b0;
                if (tap_armed && held < 32'(cfg_copy.long_press_ms) &&
                        held >= 32'(cfg_copy.tap_min_ms) && held <= 32'(cfg_copy.tap_max_ms)) begin
                    tap_armed     = 1'b0;
                    last_tap_time = now;
                    res.short_tap = 1'b1;
                end
            end
        end
        res.touched_now = pressing;
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        tpc_result_t want;
        tpc_result_t got;
        int          errs;
        errs = 0;
        if (!aresetn) begin
            cfg_copy      = CFG_RESET;
            pressing      = 1'b0;
            press_start   = '0;
            tap_armed     = 1'b0;
            last_tap_time = '0;
            expected_results.delete();
            outstanding <= 0;
            fail_count  <= 0;
        end else begin
            // A result leaves before the poll of the same edge is predicted.
            if (m_tvalid && m_tready) begin
                got = m_tdata[RESULT_W-1:0];
                if (expected_results.size() == 0) begin
                    $error("result 0x%02h arrived with no poll awaiting it", m_tdata);
                    errs++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.long_press !== want.long_press) begin
                        $error("long_press: expected %0b, got %0b", want.long_press,
                               got.long_press);
                        errs++;
                    end
                    if (got.short_tap !== want.short_tap) begin
                        $error("short_tap: expected %0b, got %0b", want.short_tap, got.short_tap);
                        errs++;
                    end
                    if (got.touched_now !== want.touched_now) begin
                        $error("touched_now: expected %0b, got %0b", want.touched_now,
                               got.touched_now);
                        errs++;
                    end
                    if (m_tdata[OUT_TDATA_W-1:RESULT_W] !== '0) begin
                        $error("padding: expected 0, got %0b", m_tdata[OUT_TDATA_W-1:RESULT_W]);
                        errs++;
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_TOUCH_THRESHOLD: cfg_copy.touch_threshold = cfg_wr_data;
                    REG_LONG_PRESS_MS:   cfg_copy.long_press_ms   = cfg_wr_data;
                    REG_LOCKOUT_MS:      cfg_copy.lockout_ms      = cfg_wr_data;
                    REG_TAP_MIN_MS:      cfg_copy.tap_min_ms      = cfg_wr_data;
                    REG_TAP_MAX_MS:      cfg_copy.tap_max_ms      = cfg_wr_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(classify_poll(s_tuser, s_tdata[TIME_W-1:0],
                                                         poll_touched(s_tdata)));
            end
            outstanding <= expected_results.size();
            fail_count  <= fail_count + errs;
        end
    end

endmodule

/* tb/touch_press_classifier_tb.sv */
`timescale 1ns / 1ps
// Testbench top of the touch press classifier: clock, reset, poll stimulus, result
// back-pressure, configuration phases and the verdict. Depends on tpc_pkg,
// touch_press_classifier and tpc_press_checker.
module touch_press_classifier_tb;
    import tpc_pkg::*;

    localparam int NUM_READINGS = 5;
    localparam int S_TDATA_W    = TIME_W + NUM_READINGS * RD_W;
    localparam int RANDOM_POLLS = 1500;
    localparam int PHASES       = 10;

    typedef logic [NUM_READINGS-1:0][RD_W-1:0] reading_set_t;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr    = '0;
    logic [CFG_W-1:0]       cfg_wr_data = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata     = '0;
    logic                   s_tuser     = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    int                     outstanding;
    int                     fail_count;

    // The stimulus shapes its timestamps and readings around the settings in force,
    // so it keeps its own note of them and of the millisecond clock it has reached.
    tpc_cfg_t          cur_cfg = CFG_RESET;
    logic [TIME_W-1:0] clock_ms = '0;
    bit                no_gaps  = 1'b0;
    int                polls_sent = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    touch_press_classifier #(
        .NUM_READINGS (NUM_READINGS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),     // now_ms, reading_a .. reading_e from the lowest bit up
        .s_tuser     (s_tuser),     // kind
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)      // long_press, short_tap, touched_now, zero padding
    );

    tpc_press_checker #(
        .NUM_READINGS (NUM_READINGS)
    ) i_press_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    // Idle lengths for both sides: mostly none or short, now and then a long one.
    function automatic int idle_cycles();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic pick_kind(input int pct_short);
        return ($urandom_range(0, 99) < pct_short) ? KIND_SHORT_CHECK : KIND_LONG_CHECK;
    endfunction

    // A span of time near a boundary of the block: just below, on, just above, or somewhere
    // in a range around it, now and then a short span from zero. Below zero wraps, which is wanted as well.
    function automatic logic [TIME_W-1:0] pick_span(input logic [TIME_W-1:0] base);
        case ($urandom_range(0, 5))
            0: return base - 1;
            1: return base;
            2: return base + 1;
            3: return $urandom_range(0, 20);
            default: return $urandom_range(0, 2 * base + 10);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_reg(input int unsigned lo, input int unsigned hi,
                                                  input int unsigned typical_hi);
        case ($urandom_range(0, 7))
            0: return CFG_W'(lo);
            1: return CFG_W'(hi);
            default: return CFG_W'($urandom_range(lo, typical_hi));
        endcase
    endfunction

    // Readings whose truncated average lies on the wanted side of the threshold. The
    // average sits on the threshold or one below it now and then; the readings spread
    // around it so that the lanes differ. With a zero threshold nothing can be touched.
    function automatic reading_set_t readings_for(input bit touched);
        reading_set_t r;
        int unsigned  thr;
        int unsigned  target;
        int unsigned  spread;
        int unsigned  extra;
        int           i;
        thr = 32'(cur_cfg.touch_threshold);
        if (touched && thr > 0) begin
            case ($urandom_range(0, 3))
                0: target = thr - 1;
                1: target = $urandom_range(0, (thr > 64) ? 63 : thr - 1);
                default: target = $urandom_range(0, thr - 1);
            endcase
        end else begin
            case ($urandom_range(0, 3))
                0: target = thr;
                1: target = 65535;
                default: target = $urandom_range(thr, 65535);
            endcase
        end
        spread = $urandom_range(0, (target < 65535 - target) ? target : 65535 - target);
        extra  = $urandom_range(0, 4);
        for (i = 0; i < NUM_READINGS; i++) begin
            r[i] = RD_W'(target);
        end
        r[0] = RD_W'(target + spread);
        r[1] = RD_W'(target - spread);
        if (target + extra <= 65535) begin
            r[2] = RD_W'(target + extra);
        end
        return r;
    endfunction

    // One poll transfer. Valid stays high into the next poll unless a gap follows, so
    // it is never lowered and raised again within one time step.
    task automatic send_poll(input logic kind, input logic [TIME_W-1:0] now,
                             input reading_set_t r);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {r, now};
        do @(posedge aclk); while (!s_tready);
        polls_sent++;
        gap = no_gaps ? 0 : idle_cycles();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop sending and wait for every result still owed. The count from the checker is
    // registered, so the task waits on the clock before its first look.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic put_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(posedge aclk);
    endtask

    task automatic write_config(input tpc_cfg_t c);
        put_reg(REG_TOUCH_THRESHOLD, c.touch_threshold);
        put_reg(REG_LONG_PRESS_MS, c.long_press_ms);
        put_reg(REG_LOCKOUT_MS, c.lockout_ms);
        put_reg(REG_TAP_MIN_MS, c.tap_min_ms);
        put_reg(REG_TAP_MAX_MS, c.tap_max_ms);
        cfg_wr_en <= 1'b0;
        cur_cfg = c;
    endtask

    // One press as a user would make it: a rest near the lockout window, a few touched
    // polls of either kind spread over the hold, then the release. The hold is chosen
    // near one of the tap limits or the long-press duration. Now and then the last
    // poll still sees a touch, so the press carries on into the next gesture.
    task automatic run_gesture();
        logic [TIME_W-1:0] t0;
        logic [TIME_W-1:0] held;
        logic [TIME_W-1:0] at;
        int                presses;
        int                i;
        case ($urandom_range(0, 2))
            0: held = pick_span(TIME_W'(cur_cfg.tap_min_ms));
            1: held = pick_span(TIME_W'(cur_cfg.tap_max_ms));
            default: held = pick_span(TIME_W'(cur_cfg.long_press_ms));
        endcase
        clock_ms += pick_span(TIME_W'(cur_cfg.lockout_ms));
        t0 = clock_ms;
        presses = $urandom_range(1, 4);
        for (i = 0; i < presses; i++) begin
            at = t0 + TIME_W'((64'(held) * i) / presses);
            send_poll(pick_kind((i == 0) ? 75 : 50), at, readings_for(1'b1));
        end
        send_poll(pick_kind(80), t0 + held, readings_for($urandom_range(0, 5) == 0));
        clock_ms = t0 + held;
    endtask

    // Polls with no gesture behind them: random kinds, steps forward or jumps anywhere on the
    // 32-bit clock, and readings that are often fully random.
    task automatic noise_burst();
        int           n;
        int           i;
        reading_set_t r;
        n = $urandom_range(1, 6);
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                clock_ms = $urandom();
            end else begin
                clock_ms += $urandom_range(0, 3000);
            end
            if ($urandom_range(0, 1) == 0) begin
                r = reading_set_t'({$urandom(), $urandom(), $urandom()});
            end else begin
                r = readings_for($urandom_range(0, 1) == 1);
            end
            send_poll(pick_kind(50), clock_ms, r);
        end
    endtask

    // The result side accepts in runs of random length, with stalls of random length
    // between them and now and then a long run with no stall at all.
    initial begin : result_backpressure
        int run_len;
        int stall_len;
        while (!aresetn) @(posedge aclk);
        forever begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 12);
            m_tready <= 1'b1;
            repeat (run_len) @(posedge aclk);
            stall_len = idle_cycles();
            if (stall_len > 0) begin
                m_tready <= 1'b0;
                repeat (stall_len) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        tpc_cfg_t     plan [4];
        tpc_cfg_t     next_cfg;
        reading_set_t all_low;
        reading_set_t all_high;
        reading_set_t on_threshold;
        reading_set_t below_threshold;
        reading_set_t alternating;
        int           phase;
        int           goal;

        // The first phases cover the settings at their extremes: the reset values
        // written back, everything at its lowest, everything at its highest, and tap
        // limits that cross so that no tap can ever qualify.
        plan[0] = CFG_RESET;
        plan[1] = '{touch_threshold: 16'd0, long_press_ms: 16'd1, lockout_ms: 16'd0,
                    tap_min_ms: 16'd0, tap_max_ms: 16'd0};
        plan[2] = '{default: 16'hFFFF};
        plan[3] = '{touch_threshold: 16'd40, long_press_ms: 16'd1000, lockout_ms: 16'd0,
                    tap_min_ms: 16'd600, tap_max_ms: 16'd300};

        // Reading sets for the directed polls, valid for the reset threshold of 40.
        all_low         = '0;
        all_high        = '1;
        on_threshold    = {NUM_READINGS{16'd40}};
        below_threshold = {16'd43, 16'd39, 16'd39, 16'd39, 16'd39};
        alternating     = {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed polls under the reset settings, written nowhere yet.
        // A short check straight after reset falls inside the lockout of a tap at zero.
        send_poll(KIND_SHORT_CHECK, 32'd500, all_low);
        // A long press held to exactly the duration, checked one millisecond short first.
        send_poll(KIND_LONG_CHECK, 32'd0, all_low);
        send_poll(KIND_LONG_CHECK, 32'd999, all_low);
        send_poll(KIND_LONG_CHECK, 32'd1000, all_low);
        // An average one below the threshold touches; one on the threshold releases.
        send_poll(KIND_LONG_CHECK, 32'd1200, below_threshold);
        send_poll(KIND_LONG_CHECK, 32'd1300, on_threshold);
        // A tap exactly as long as the shortest accepted tap.
        send_poll(KIND_SHORT_CHECK, 32'd5000, below_threshold);
        send_poll(KIND_SHORT_CHECK, 32'd5100, all_high);
        // The lockout after that tap, its last millisecond and its end.
        send_poll(KIND_SHORT_CHECK, 32'd6099, all_low);
        send_poll(KIND_SHORT_CHECK, 32'd6100, all_low);
        // A release one millisecond too early for a tap still ends the press.
        send_poll(KIND_SHORT_CHECK, 32'd6199, all_high);
        // A release after exactly the long-press duration is no tap.
        send_poll(KIND_SHORT_CHECK, 32'd7000, all_low);
        send_poll(KIND_SHORT_CHECK, 32'd8000, all_high);
        // A tap across the wrap of the millisecond clock.
        send_poll(KIND_SHORT_CHECK, 32'hFFFF_FF00, all_low);
        send_poll(KIND_SHORT_CHECK, 32'h0000_0010, all_high);
        // A locked-out short check in the middle of a long press changes nothing,
        // then a long check sees the release and clears the press.
        send_poll(KIND_LONG_CHECK, 32'h0000_0020, all_low);
        send_poll(KIND_SHORT_CHECK, 32'h0000_0030, all_low);
        send_poll(KIND_LONG_CHECK, 32'h0000_0030, all_high);
        // Readings with every bit set and clear, on the last millisecond of the clock.
        send_poll(KIND_SHORT_CHECK, 32'hFFFF_FFFF, alternating);
        send_poll(KIND_LONG_CHECK, 32'hAAAA_5555, alternating);

        for (phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            repeat (4) @(posedge aclk);
            if (phase < 4) begin
                next_cfg = plan[phase];
            end else begin
                next_cfg.touch_threshold = pick_reg(0, 65535, 65535);
                next_cfg.long_press_ms   = pick_reg(1, 65535, 3000);
                next_cfg.lockout_ms      = pick_reg(0, 65535, 3000);
                next_cfg.tap_min_ms      = pick_reg(0, 65535, 1500);
                next_cfg.tap_max_ms      = pick_reg(0, 65535, 3000);
            end
            write_config(next_cfg);
            // Every third phase the sender keeps valid high without a break.
            no_gaps = (phase % 3 == 2);
            goal = polls_sent + RANDOM_POLLS / PHASES;
            while (polls_sent < goal) begin
                // Now and then the sender holds off until every result is back.
                if ($urandom_range(0, 39) == 0) begin
                    wait_drained();
                end
                if ($urandom_range(0, 4) == 0) begin
                    noise_burst();
                end else begin
                    run_gesture();
                end
            end
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // A correct run takes well under a tenth of this; a hung handshake ends here.
    initial begin : watchdog
        #(8_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule
